// ===== src/ihl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihl_pkg: shared types and constants for the ICMP host liveness table
// Request/result codes, register reset values, the table row layout, and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ihl_pkg;

    // Request type codes
    localparam logic [2:0] REQ_WRITE  = 3'd0;
    localparam logic [2:0] REQ_SEND   = 3'd1;
    localparam logic [2:0] REQ_REPLY  = 3'd2;
    localparam logic [2:0] REQ_STATUS = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;

    // Result kind codes
    localparam logic [2:0] KIND_ECHO  = 3'd0;
    localparam logic [2:0] KIND_UP    = 3'd1;
    localparam logic [2:0] KIND_DOWN  = 3'd2;
    localparam logic [2:0] KIND_STATS = 3'd3;
    localparam logic [2:0] KIND_DONE  = 3'd4;

    // Register reset values and fixed checksum word (type 8, code 0)
    localparam logic [15:0] ECHO_ID_RST    = 16'h9cd0;
    localparam logic [15:0] ECHO_SEQ_RST   = 16'h34d1;
    localparam logic [15:0] CSUM_TYPE_WORD = 16'h0800;
    localparam logic [7:0]  ICMP_ECHO_REPLY = 8'd0;

    // One table row kept in memory
    typedef struct packed {
        logic [31:0] target;
        logic [31:0] sent_addr;
        logic [31:0] send_time;
        logic [31:0] sent_ctr;
        logic [31:0] recv_ctr;
        logic [63:0] resp_sum;
        logic [31:0] resp_count;
    } row_t;

    // Controller -> datapath
    typedef struct packed {
        logic capture;
        logic clr_ctr;
        logic inc_ctr;
        logic rd_en;
        logic apply;
        logic load_done;
    } ctrl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic known;
        logic is_sweep;
        logic entry_active;
        logic last_entry;
        logic emit_needed;
        logic out_free;
    } dp_status_t;

endpackage

// ===== src/ihl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihl_ctrl: request sequencer
// Accepts a request, walks the table for sweeps, and orders the fetch, apply
// and done steps against the output register.
// ----------------------------------------------------------------------------
module ihl_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  ihl_pkg::dp_status_t   stat,
    output ihl_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_APPLY = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    cmd.clr_ctr = 1'b1;
                    state_next  = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (!stat.known)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.is_sweep && !stat.entry_active)
                begin
                    // inactive entry: skip without a read
                    if (stat.last_entry)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd.inc_ctr = 1'b1;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                // hold while a result has nowhere to go
                if (!stat.emit_needed || stat.out_free)
                begin
                    cmd.apply = 1'b1;
                    if (!stat.is_sweep)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (stat.last_entry)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd.inc_ctr = 1'b1;
                        state_next  = ST_FETCH;
                    end
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/ihl_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihl_dpath: host table datapath
// Holds the request, the per-host flags, the row memory and the output
// register; computes entry updates and the echo request checksum.
// ----------------------------------------------------------------------------
module ihl_dpath
#(
    parameter int HOSTS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ihl_pkg::ctrl_cmd_t    cmd,
    output ihl_pkg::dp_status_t   stat,
    input  logic [15:0]           echo_identifier,
    input  logic [15:0]           echo_seq_value,
    input  logic [2:0]            req_type,
    input  logic [7:0]            host_index,
    input  logic                  host_valid,
    input  logic                  host_is_icmp,
    input  logic [31:0]           host_address,
    input  logic [7:0]            msg_type,
    input  logic [15:0]           echo_ident,
    input  logic [15:0]           echo_sequence,
    input  logic [31:0]           now_us,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic [2:0]            kind,
    output logic [5:0]            out_index,
    output logic [31:0]           out_address,
    output logic [15:0]           echo_checksum,
    output logic [31:0]           sent_count,
    output logic [31:0]           received_count,
    output logic [63:0]           resp_total,
    output logic [31:0]           resp_samples,
    output logic                  host_up,
    output logic                  awaiting,
    output logic                  any_active,
    output logic                  last
);

    localparam int AW = (HOSTS > 1) ? $clog2(HOSTS) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(HOSTS - 1);
    localparam logic [7:0]    HOSTS_B  = 8'(HOSTS);

    // Internet checksum of the echo request body
    function automatic logic [15:0] echo_csum(input logic [15:0] id,
                                              input logic [15:0] sq,
                                              input logic [7:0]  ix);
        logic [17:0] s;
        logic [16:0] f;
        s = 18'(ihl_pkg::CSUM_TYPE_WORD) + 18'(id) + 18'(sq) + {2'b00, ix, 8'h00};
        f = 17'(s[17:16]) + 17'(s[15:0]);
        f = 17'(f[16]) + {1'b0, f[15:0]};
        return ~f[15:0];
    endfunction

    // Captured request
    logic [2:0]  req_reg;
    logic [7:0]  idx_reg;
    logic        hv_reg;
    logic        hicmp_reg;
    logic [31:0] addr_reg;
    logic [7:0]  itype_reg;
    logic [15:0] ident_reg;
    logic [15:0] seq_reg;
    logic [31:0] now_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg   <= req_type;
            idx_reg   <= host_index;
            hv_reg    <= host_valid;
            hicmp_reg <= host_is_icmp;
            addr_reg  <= host_address;
            itype_reg <= msg_type;
            ident_reg <= echo_ident;
            seq_reg   <= echo_sequence;
            now_reg   <= now_us;
        end
    end

    // Sweep counter
    logic [AW-1:0] ctr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg <= '0;
        end
        else if (cmd.clr_ctr)
        begin
            ctr_reg <= '0;
        end
        else if (cmd.inc_ctr)
        begin
            ctr_reg <= ctr_reg + AW'(1);
        end
    end

    // Per-host flags; live marks rows that hold written data
    logic [HOSTS-1:0] valid_reg, valid_next;
    logic [HOSTS-1:0] icmp_reg,  icmp_next;
    logic [HOSTS-1:0] pend_reg,  pend_next;
    logic [HOSTS-1:0] up_reg,    up_next;
    logic [HOSTS-1:0] live_reg;

    logic is_sweep;
    logic in_range;
    logic [AW-1:0] sel_addr;

    assign is_sweep = (req_reg == ihl_pkg::REQ_SEND) || (req_reg == ihl_pkg::REQ_STATUS);
    assign in_range = (idx_reg < HOSTS_B);
    assign sel_addr = is_sweep ? ctr_reg : idx_reg[AW-1:0];

    // Row memory, registered read
    ihl_pkg::row_t mem [HOSTS];
    ihl_pkg::row_t rdata_reg;
    logic          live_q_reg;
    logic [AW-1:0] addr_q_reg;
    ihl_pkg::row_t row_q;
    ihl_pkg::row_t row_new;
    logic          we;

    always_ff @(posedge clk)
    begin
        if (cmd.apply && we)
        begin
            mem[addr_q_reg] <= row_new;
        end
        if (cmd.rd_en)
        begin
            rdata_reg  <= mem[sel_addr];
            live_q_reg <= live_reg[sel_addr];
            addr_q_reg <= sel_addr;
        end
    end

    assign row_q = live_q_reg ? rdata_reg : '0;

    // Entry update
    logic        emit;
    logic        show;
    logic [2:0]  kind_n;
    logic [15:0] csum_n;
    logic        match;
    logic [31:0] recv_inc;

    always_comb
    begin
        row_new    = row_q;
        we         = 1'b0;
        valid_next = valid_reg;
        icmp_next  = icmp_reg;
        pend_next  = pend_reg;
        up_next    = up_reg;
        emit       = 1'b0;
        show       = 1'b0;
        kind_n     = ihl_pkg::KIND_DONE;
        csum_n     = '0;
        recv_inc   = row_q.recv_ctr + 32'd1;
        match      = (itype_reg == ihl_pkg::ICMP_ECHO_REPLY) &&
                     (ident_reg == echo_identifier) && (seq_reg == echo_seq_value) &&
                     in_range && valid_reg[addr_q_reg] && (row_q.sent_addr == addr_reg);
        case (req_reg)
            ihl_pkg::REQ_WRITE:
            begin
                if (in_range)
                begin
                    we                     = 1'b1;
                    row_new.target         = addr_reg;
                    valid_next[addr_q_reg] = hv_reg;
                    icmp_next[addr_q_reg]  = hicmp_reg;
                end
            end
            ihl_pkg::REQ_SEND:
            begin
                pend_next[addr_q_reg] = 1'b1;
                if (row_q.target != 32'd0)
                begin
                    we                = 1'b1;
                    row_new.sent_addr = row_q.target;
                    row_new.send_time = now_reg;
                    row_new.sent_ctr  = row_q.sent_ctr + 32'd1;
                    emit              = 1'b1;
                    show              = 1'b1;
                    kind_n            = ihl_pkg::KIND_ECHO;
                    csum_n            = echo_csum(echo_identifier, echo_seq_value,
                                                  8'(addr_q_reg));
                end
            end
            ihl_pkg::REQ_REPLY:
            begin
                if (match)
                begin
                    we                    = 1'b1;
                    row_new.recv_ctr      = (recv_inc > row_q.sent_ctr) ? row_q.sent_ctr
                                                                        : recv_inc;
                    row_new.resp_sum      = row_q.resp_sum +
                                            {32'd0, now_reg - row_q.send_time};
                    row_new.resp_count    = row_q.resp_count + 32'd1;
                    pend_next[addr_q_reg] = 1'b0;
                end
            end
            ihl_pkg::REQ_STATUS:
            begin
                if (!pend_reg[addr_q_reg] && !up_reg[addr_q_reg])
                begin
                    up_next[addr_q_reg] = 1'b1;
                    emit                = 1'b1;
                    show                = 1'b1;
                    kind_n              = ihl_pkg::KIND_UP;
                end
                else if (pend_reg[addr_q_reg] && up_reg[addr_q_reg])
                begin
                    up_next[addr_q_reg] = 1'b0;
                    emit                = 1'b1;
                    show                = 1'b1;
                    kind_n              = ihl_pkg::KIND_DOWN;
                end
                pend_next[addr_q_reg] = 1'b0;
            end
            ihl_pkg::REQ_READ:
            begin
                emit   = 1'b1;
                show   = in_range;
                kind_n = ihl_pkg::KIND_STATS;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            icmp_reg  <= '0;
            pend_reg  <= '0;
            up_reg    <= '0;
            live_reg  <= '0;
        end
        else if (cmd.apply)
        begin
            valid_reg <= valid_next;
            icmp_reg  <= icmp_next;
            pend_reg  <= pend_next;
            up_reg    <= up_next;
            if (we)
            begin
                live_reg[addr_q_reg] <= 1'b1;
            end
        end
    end

    logic active_any;
    assign active_any = |(valid_reg & icmp_reg);

    // Output register
    logic        out_valid_reg;
    logic [2:0]  kind_reg;
    logic [5:0]  oidx_reg;
    logic [31:0] oaddr_reg;
    logic [15:0] csum_reg;
    logic [31:0] sent_reg;
    logic [31:0] recv_reg;
    logic [63:0] rsum_reg;
    logic [31:0] rcnt_reg;
    logic        up_o_reg;
    logic        pend_o_reg;
    logic        act_reg;
    logic        last_reg;
    logic        out_free;

    assign out_free = !out_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((cmd.apply && emit) || cmd.load_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply && emit)
        begin
            kind_reg   <= kind_n;
            oidx_reg   <= is_sweep ? 6'(addr_q_reg) : idx_reg[5:0];
            oaddr_reg  <= show ? row_new.target : 32'd0;
            csum_reg   <= csum_n;
            sent_reg   <= show ? row_new.sent_ctr : 32'd0;
            recv_reg   <= show ? row_new.recv_ctr : 32'd0;
            rsum_reg   <= show ? row_new.resp_sum : 64'd0;
            rcnt_reg   <= show ? row_new.resp_count : 32'd0;
            up_o_reg   <= show & up_next[addr_q_reg];
            pend_o_reg <= show & pend_next[addr_q_reg];
            act_reg    <= active_any;
            last_reg   <= (req_reg == ihl_pkg::REQ_READ);
        end
        else if (cmd.load_done)
        begin
            kind_reg   <= ihl_pkg::KIND_DONE;
            oidx_reg   <= '0;
            oaddr_reg  <= '0;
            csum_reg   <= '0;
            sent_reg   <= '0;
            recv_reg   <= '0;
            rsum_reg   <= '0;
            rcnt_reg   <= '0;
            up_o_reg   <= 1'b0;
            pend_o_reg <= 1'b0;
            act_reg    <= active_any;
            last_reg   <= 1'b1;
        end
    end

    assign rsp_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign out_index      = oidx_reg;
    assign out_address    = oaddr_reg;
    assign echo_checksum  = csum_reg;
    assign sent_count     = sent_reg;
    assign received_count = recv_reg;
    assign resp_total     = rsum_reg;
    assign resp_samples   = rcnt_reg;
    assign host_up        = up_o_reg;
    assign awaiting       = pend_o_reg;
    assign any_active     = act_reg;
    assign last           = last_reg;

    // Status to controller
    always_comb
    begin
        stat.known        = (req_reg == ihl_pkg::REQ_WRITE) || (req_reg == ihl_pkg::REQ_SEND) ||
                            (req_reg == ihl_pkg::REQ_REPLY) || (req_reg == ihl_pkg::REQ_STATUS) ||
                            (req_reg == ihl_pkg::REQ_READ);
        stat.is_sweep     = is_sweep;
        stat.entry_active = valid_reg[ctr_reg] & icmp_reg[ctr_reg];
        stat.last_entry   = (ctr_reg == LAST_IDX);
        stat.emit_needed  = emit;
        stat.out_free     = out_free;
    end

endmodule

// ===== src/icmp_host_liveness_table.sv =====
`timescale 1ns / 1ps
// Write, reply and read pass through a row memory read and then an update from
// accept; a read result is registered in the update step. Sweeps skip an
// inactive entry without a read, take a row memory read then an update for an
// active entry, then a done result; results wait for a free output register.
// One request in flight; the next is taken once the last result is in the
// output register. Reset clears flags and marks every row unwritten (reads as
// zero); registers return to their defaults.
// ----------------------------------------------------------------------------
// icmp_host_liveness_table: ICMP echo host liveness table
// Table of monitored hosts with echo request generation, reply matching,
// up/down tracking and statistics readout; APB register port.
// ----------------------------------------------------------------------------
module icmp_host_liveness_table
#(
    parameter int HOSTS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request channel
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [2:0]  req_type,
    input  logic [7:0]  host_index,
    input  logic        host_valid,
    input  logic        host_is_icmp,
    input  logic [31:0] host_address,
    input  logic [7:0]  msg_type,
    input  logic [15:0] echo_ident,
    input  logic [15:0] echo_sequence,
    input  logic [31:0] now_us,
    // result channel
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [2:0]  kind,
    output logic [5:0]  out_index,
    output logic [31:0] out_address,
    output logic [15:0] echo_checksum,
    output logic [31:0] sent_count,
    output logic [31:0] received_count,
    output logic [63:0] resp_total,
    output logic [31:0] resp_samples,
    output logic        host_up,
    output logic        awaiting,
    output logic        any_active,
    output logic        last
);

    // Configuration registers
    logic [15:0] ident_cfg_reg;
    logic [15:0] seq_cfg_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ident_cfg_reg <= ihl_pkg::ECHO_ID_RST;
            seq_cfg_reg   <= ihl_pkg::ECHO_SEQ_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
            begin
                seq_cfg_reg <= pwdata[15:0];
            end
            else
            begin
                ident_cfg_reg <= pwdata[15:0];
            end
        end
    end

    assign prdata = paddr[2] ? {16'd0, seq_cfg_reg} : {16'd0, ident_cfg_reg};

    ihl_pkg::ctrl_cmd_t  cmd;
    ihl_pkg::dp_status_t stat;

    ihl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ihl_dpath #(.HOSTS(HOSTS)) u_dpath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .echo_identifier (ident_cfg_reg),
        .echo_seq_value  (seq_cfg_reg),
        .req_type        (req_type),
        .host_index      (host_index),
        .host_valid      (host_valid),
        .host_is_icmp    (host_is_icmp),
        .host_address    (host_address),
        .msg_type        (msg_type),
        .echo_ident      (echo_ident),
        .echo_sequence   (echo_sequence),
        .now_us          (now_us),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .kind            (kind),
        .out_index       (out_index),
        .out_address     (out_address),
        .echo_checksum   (echo_checksum),
        .sent_count      (sent_count),
        .received_count  (received_count),
        .resp_total      (resp_total),
        .resp_samples    (resp_samples),
        .host_up         (host_up),
        .awaiting        (awaiting),
        .any_active      (any_active),
        .last            (last)
    );

    // Requests are never accepted back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted on back-to-back cycles");

    // Every row read is followed by its update step, never another read
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |=> !cmd.rd_en)
        else $error("row read not followed by apply");

    // A result appears only from an apply or done load
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(cmd.apply || cmd.load_done))
        else $error("result valid without a load");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the ICMP host liveness table
// Drives host writes, send and status sweeps, echo replies and reads through
// a valid/ready request channel, predicts every result with a local model of
// the host table and compares results field by field. Registers are changed
// over APB between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

    localparam int HOSTS = 32;
    localparam int LIMIT = 2000000;
    localparam logic [2:0] ADDR_ID   = 3'd0;
    localparam logic [2:0] ADDR_SEQ  = 3'd4;
    localparam logic [2:0] REQ_SPARE = 3'd5;
    localparam logic [2:0] REQ_BAD   = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [5:0]  index;
        logic [31:0] address;
        logic [15:0] csum;
        logic [31:0] sent;
        logic [31:0] recv;
        logic [63:0] total;
        logic [31:0] samples;
        logic        up;
        logic        waiting;
        logic        active;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [2:0]  rtype;
        logic [7:0]  index;
        logic        hvalid;
        logic        hicmp;
        logic [31:0] addr;
        logic [7:0]  itype;
        logic [15:0] ident;
        logic [15:0] seq;
        logic [31:0] now;
    } request_t;

    logic clk, rst_n;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic req_valid, req_ready, rsp_valid, rsp_ready;
    logic [2:0] req_type;
    logic [7:0] host_index, msg_type;
    logic host_valid, host_is_icmp;
    logic [31:0] host_address, now_us;
    logic [15:0] echo_ident, echo_sequence;
    logic [2:0] kind;
    logic [5:0] out_index;
    logic [31:0] out_address, sent_count, received_count, resp_samples;
    logic [15:0] echo_checksum;
    logic [63:0] resp_total;
    logic host_up, awaiting, any_active, last;

    icmp_host_liveness_table #(.HOSTS(HOSTS)) i_dut (.*);

    // Host table model
    logic [15:0] cfg_ident, cfg_seq;
    logic        t_valid[HOSTS], t_icmp[HOSTS], t_pend[HOSTS], t_up[HOSTS];
    logic [31:0] t_target[HOSTS], t_saddr[HOSTS], t_stime[HOSTS];
    logic [31:0] t_sent[HOSTS], t_recv[HOSTS], t_cnt[HOSTS];
    logic [63:0] t_sum[HOSTS];

    result_t expected_results[$];
    int errors = 0;
    int cycles = 0;
    bit quiet = 0;
    bit rsp_stall_on = 1;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [15:0] echo_csum(input int idx);
        logic [31:0] s;
        s = 32'h0800 + cfg_ident + cfg_seq + ((idx & 8'hFF) << 8);
        s = (s >> 16) + (s & 32'hFFFF);
        s = s + (s >> 16);
        return ~s[15:0];
    endfunction

    function automatic bit table_live();
        for (int i = 0; i < HOSTS; i++)
            if (t_valid[i] && t_icmp[i]) return 1;
        return 0;
    endfunction

    function automatic result_t make_result(input logic [2:0] k, input int idx,
                                            input bit entry, input logic [15:0] cs,
                                            input bit act, input bit lst);
        result_t r;
        r = '0;
        r.kind = k;
        r.index = idx[5:0];
        if (entry && idx < HOSTS)
        begin
            r.address = t_target[idx];
            r.sent = t_sent[idx];
            r.recv = t_recv[idx];
            r.total = t_sum[idx];
            r.samples = t_cnt[idx];
            r.up = t_up[idx];
            r.waiting = t_pend[idx];
        end
        r.csum = cs;
        r.active = act;
        r.last = lst;
        return r;
    endfunction

    // Apply one request to the table model and queue its results
    task automatic predict_request(input request_t q);
        bit act;
        int idx;
        idx = q.index;
        act = table_live();
        case (q.rtype)
            ihl_pkg::REQ_WRITE:
                if (idx < HOSTS)
                begin
                    t_valid[idx] = q.hvalid;
                    t_icmp[idx] = q.hicmp;
                    t_target[idx] = q.addr;
                end
            ihl_pkg::REQ_SEND:
            begin
                for (int i = 0; i < HOSTS; i++)
                begin
                    if (!(t_valid[i] && t_icmp[i])) continue;
                    t_pend[i] = 1;
                    if (t_target[i] == 0) continue;
                    t_saddr[i] = t_target[i];
                    t_stime[i] = q.now;
                    t_sent[i] = t_sent[i] + 1;
                    expected_results.push_back(
                        make_result(ihl_pkg::KIND_ECHO, i, 1, echo_csum(i), act, 0));
                end
                expected_results.push_back(
                    make_result(ihl_pkg::KIND_DONE, 0, 0, 0, act, 1));
            end
            ihl_pkg::REQ_REPLY:
                if (q.itype == ihl_pkg::ICMP_ECHO_REPLY && q.ident == cfg_ident &&
                    q.seq == cfg_seq && idx < HOSTS && t_valid[idx] &&
                    t_saddr[idx] == q.addr)
                begin
                    t_recv[idx] = t_recv[idx] + 1;
                    if (t_recv[idx] > t_sent[idx]) t_recv[idx] = t_sent[idx];
                    t_pend[idx] = 0;
                    t_sum[idx] = t_sum[idx] + 64'(32'(q.now - t_stime[idx]));
                    t_cnt[idx] = t_cnt[idx] + 1;
                end
            ihl_pkg::REQ_STATUS:
            begin
                for (int i = 0; i < HOSTS; i++)
                begin
                    if (!(t_valid[i] && t_icmp[i])) continue;
                    if (!t_pend[i] && !t_up[i])
                    begin
                        t_up[i] = 1;
                        expected_results.push_back(
                            make_result(ihl_pkg::KIND_UP, i, 1, 0, act, 0));
                    end
                    else if (t_pend[i] && t_up[i])
                    begin
                        t_up[i] = 0;
                        t_pend[i] = 0;
                        expected_results.push_back(
                            make_result(ihl_pkg::KIND_DOWN, i, 1, 0, act, 0));
                    end
                    t_pend[i] = 0;
                end
                expected_results.push_back(
                    make_result(ihl_pkg::KIND_DONE, 0, 0, 0, act, 1));
            end
            ihl_pkg::REQ_READ:
                expected_results.push_back(
                    make_result(ihl_pkg::KIND_STATS, idx, 1, 0, act, 1));
            default: ;
        endcase
    endtask

    // Result checker
    always @(posedge clk)
    begin
        result_t got, exp_r;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            got = '{kind, out_index, out_address, echo_checksum, sent_count,
                    received_count, resp_total, resp_samples, host_up, awaiting,
                    any_active, last};
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %h", $time, got);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r)
                begin
                    errors++;
                    $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
                end
            end
        end
    end

    // Result-side stalls in bursts
    initial
    begin
        int n;
        rsp_ready = 0;
        @(posedge rst_n);
        forever
        begin
            n = $urandom_range(1, 15);
            if (rsp_stall_on && $urandom_range(0, 2) == 0)
                rsp_ready <= 0;
            else
                rsp_ready <= 1;
            repeat (n) @(posedge clk);
        end
    end

    // Valid stays high after an accept until the next idle burst or wait_idle
    task automatic send_request(input request_t q);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        req_valid <= 1;
        {req_type, host_index, host_valid, host_is_icmp, host_address,
         msg_type, echo_ident, echo_sequence, now_us} <= q;
        do @(posedge clk); while (!req_ready);
        predict_request(q);
    endtask

    task automatic wait_idle();
        req_valid <= 0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (2 * HOSTS + 10) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] a, input logic [31:0] v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (a == ADDR_ID) cfg_ident = v[15:0];
        else cfg_seq = v[15:0];
        @(posedge clk);
    endtask

    function automatic request_t mk(input logic [2:0] t, input logic [7:0] idx,
                                    input logic hv, input logic hi,
                                    input logic [31:0] a, input logic [7:0] it,
                                    input logic [15:0] id, input logic [15:0] sq,
                                    input logic [31:0] now);
        return '{t, idx, hv, hi, a, it, id, sq, now};
    endfunction

    // Random request: mostly matching replies and sweeps over a small host set
    function automatic request_t rand_request();
        request_t q;
        logic [127:0] rbits;
        int sel, idx;
        rbits = {$urandom, $urandom, $urandom, $urandom};
        q = rbits[$bits(request_t)-1:0];
        sel = $urandom_range(0, 99);
        idx = $urandom_range(0, 7);
        if (sel < 20)
        begin
            q.rtype = ihl_pkg::REQ_WRITE;
            q.index = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'(idx);
            if ($urandom_range(0, 4) == 0) q.addr = 32'd0;
            if ($urandom_range(0, 3) != 0) q.hvalid = 1'b1;
            if ($urandom_range(0, 3) != 0) q.hicmp = 1'b1;
        end
        else if (sel < 35) q.rtype = ihl_pkg::REQ_SEND;
        else if (sel < 65)
        begin
            q.rtype = ihl_pkg::REQ_REPLY;
            if ($urandom_range(0, 4) != 0)
            begin
                q.index = 8'(idx);
                q.itype = ihl_pkg::ICMP_ECHO_REPLY;
                q.ident = cfg_ident;
                q.seq = cfg_seq;
                q.addr = t_saddr[idx];
            end
        end
        else if (sel < 78) q.rtype = ihl_pkg::REQ_STATUS;
        else if (sel < 96)
        begin
            q.rtype = ihl_pkg::REQ_READ;
            if ($urandom_range(0, 9) != 0) q.index = 8'(idx);
        end
        else q.rtype = 3'($urandom_range(5, 7));
        return q;
    endfunction

    // Directed table; expected values given where obvious
    request_t dir_req[$];
    result_t  dir_exp[$];
    bit       dir_has[$];

    task automatic add_row(input request_t q, input bit has, input result_t e);
        dir_req.push_back(q);
        dir_has.push_back(has);
        dir_exp.push_back(e);
    endtask

    initial
    begin
        result_t e;
        request_t q;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        req_valid = 0;
        {req_type, host_index, host_valid, host_is_icmp, host_address,
         msg_type, echo_ident, echo_sequence, now_us} = '0;
        cfg_ident = ihl_pkg::ECHO_ID_RST;
        cfg_seq = ihl_pkg::ECHO_SEQ_RST;
        for (int i = 0; i < HOSTS; i++)
        begin
            t_valid[i] = 0; t_icmp[i] = 0; t_pend[i] = 0; t_up[i] = 0;
            t_target[i] = 0; t_saddr[i] = 0; t_stime[i] = 0;
            t_sent[i] = 0; t_recv[i] = 0; t_cnt[i] = 0; t_sum[i] = 0;
        end
        rst_n = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed part
        e = '0; e.kind = ihl_pkg::KIND_STATS; e.index = 6'd31; e.last = 1;
        add_row(mk(ihl_pkg::REQ_READ, 8'd31, 0, 0, 0, 0, 0, 0, 0), 1, e);
        e = '0; e.kind = ihl_pkg::KIND_DONE; e.last = 1;
        add_row(mk(ihl_pkg::REQ_SEND, 0, 0, 0, 0, 0, 0, 0, 0), 1, e);
        add_row(mk(ihl_pkg::REQ_WRITE, 8'd0, 1, 1, 32'hFFFF_FFFF, 0, 0, 0, 0), 0, e);
        add_row(mk(ihl_pkg::REQ_WRITE, 8'd31, 1, 1, 32'h0A00_0001, 0, 0, 0, 0), 0, e);
        add_row(mk(ihl_pkg::REQ_WRITE, 8'd5, 1, 1, 32'h0, 0, 0, 0, 0), 0, e);
        add_row(mk(ihl_pkg::REQ_WRITE, 8'd6, 1, 0, 32'h0102_0304, 0, 0, 0, 0), 0, e);
        add_row(mk(ihl_pkg::REQ_WRITE, 8'd200, 1, 1, 32'h1111_1111, 0, 0, 0, 0), 0, e);
        add_row(mk(ihl_pkg::REQ_SEND, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFF0), 0, e);
        add_row(mk(ihl_pkg::REQ_REPLY, 8'd0, 0, 0, 32'hFFFF_FFFF, ihl_pkg::ICMP_ECHO_REPLY,
                   ihl_pkg::ECHO_ID_RST, ihl_pkg::ECHO_SEQ_RST, 32'h10), 0, e);
        add_row(mk(ihl_pkg::REQ_REPLY, 8'd0, 0, 0, 32'hFFFF_FFFF, ihl_pkg::ICMP_ECHO_REPLY,
                   ihl_pkg::ECHO_ID_RST, ihl_pkg::ECHO_SEQ_RST, 32'h20), 0, e);
        add_row(mk(ihl_pkg::REQ_REPLY, 8'd31, 0, 0, 32'h0A00_0001, 8'd8,
                   ihl_pkg::ECHO_ID_RST, ihl_pkg::ECHO_SEQ_RST, 0), 0, e);
        add_row(mk(ihl_pkg::REQ_REPLY, 8'd31, 0, 0, 32'h0A00_0001, ihl_pkg::ICMP_ECHO_REPLY,
                   16'hFFFF, ihl_pkg::ECHO_SEQ_RST, 0), 0, e);
        add_row(mk(ihl_pkg::REQ_REPLY, 8'd255, 0, 0, 0, ihl_pkg::ICMP_ECHO_REPLY,
                   ihl_pkg::ECHO_ID_RST, ihl_pkg::ECHO_SEQ_RST, 0), 0, e);
        add_row(mk(ihl_pkg::REQ_STATUS, 0, 0, 0, 0, 0, 0, 0, 0), 0, e);
        add_row(mk(ihl_pkg::REQ_STATUS, 0, 0, 0, 0, 0, 0, 0, 0), 0, e);
        add_row(mk(ihl_pkg::REQ_READ, 8'd0, 0, 0, 0, 0, 0, 0, 0), 0, e);
        add_row(mk(ihl_pkg::REQ_READ, 8'd31, 0, 0, 0, 0, 0, 0, 0), 0, e);
        e = '0; e.kind = ihl_pkg::KIND_STATS; e.index = 6'd63; e.active = 1; e.last = 1;
        add_row(mk(ihl_pkg::REQ_READ, 8'd255, 0, 0, 0, 0, 0, 0, 0), 1, e);
        add_row(mk(REQ_BAD, 8'd1, 1, 1, 0, 0, 0, 0, 0), 0, e);
        add_row(mk(REQ_SPARE, 8'd1, 1, 1, 0, 0, 0, 0, 0), 0, e);
        add_row(mk(ihl_pkg::REQ_SEND, 0, 0, 0, 0, 0, 0, 0, 32'h5), 0, e);
        add_row(mk(ihl_pkg::REQ_STATUS, 0, 0, 0, 0, 0, 0, 0, 0), 0, e);

        for (int i = 0; i < dir_req.size(); i++)
        begin
            send_request(dir_req[i]);
            // Typed-in expectation must agree with the final predicted result
            if (dir_has[i])
            begin
                if (expected_results.size() == 0 || expected_results[$] !== dir_exp[i])
                begin
                    errors++;
                    $display("%0t: table row %0d expected %h model %h", $time, i,
                             dir_exp[i], (expected_results.size() == 0) ? '0
                                                                       : expected_results[$]);
                end
            end
        end
        wait_idle();

        // Random phases with register changes, extremes among them
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin reg_write(ADDR_ID, 32'h0); reg_write(ADDR_SEQ, 32'hFFFF); end
                1: begin reg_write(ADDR_ID, 32'hFFFF); reg_write(ADDR_SEQ, 32'h0); end
                5:
                begin
                    reg_write(ADDR_ID, 32'(ihl_pkg::ECHO_ID_RST));
                    reg_write(ADDR_SEQ, 32'(ihl_pkg::ECHO_SEQ_RST));
                end
                default: begin reg_write(ADDR_ID, $urandom); reg_write(ADDR_SEQ, $urandom); end
            endcase
            if (ph == 5)
            begin
                quiet = 1;
                rsp_stall_on = 0;
            end
            for (int k = 0; k < 52; k++)
            begin
                q = rand_request();
                if (ph == 2 && k % 7 == 0) q = mk(ihl_pkg::REQ_WRITE, 8'(k % 32), 1, 1,
                                                 $urandom | 1, 0, 0, 0, 0);
                send_request(q);
            end
            wait_idle();
        end

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
src/ihl_pkg.sv
src/ihl_ctrl.sv
src/ihl_dpath.sv
src/icmp_host_liveness_table.sv
tb/testbench.sv
